// ----- sv/tvd_limited_slope_defines.svh -----
// Assertion macros for the limited-slope block.
`ifndef TVD_LIMITED_SLOPE_DEFINES_SVH
`define TVD_LIMITED_SLOPE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on aclk, off during reset.
`define TVD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tvd_limited_slope: check failed");
// Next-cycle implication.
`define TVD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tvd_limited_slope: check failed");
`else
`define TVD_ASSERT_IMP(label, ante, cons)
`define TVD_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- sv/tvd_pkg.sv -----
package tvd_pkg;

    // Data word width of values and differences
    localparam int DATA_W        = 32;
    // Default number of fraction bits
    localparam int FRAC_BITS_DEF = 16;
    // Ratio magnitude bits (saturates to all ones)
    localparam int R_QB          = 31;

    typedef enum logic [1:0] {
        LIM_SUPERBEE  = 2'd0,
        LIM_MINBEE    = 2'd1,
        LIM_VANLEER   = 2'd2,
        LIM_VANALBADA = 2'd3
    } lim_mode_t;

endpackage

// ----- sv/tvd_limited_slope.sv -----
// Limited slope of one solution component (TVD reconstruction, w = 1).
// Input channel s_*: cell value and both neighbours, signed fixed point with
// FRAC_BITS fraction bits. Result channel m_*: the backward difference times
// the limiter factor, plus a flag set when a difference was clamped.
// The limiter is picked by cfg_wr_data on a cycle with cfg_wr_en high;
// change it only while no request is in flight.
// Throughput: one request per cycle, back to back, unless a stalled result holds the pipeline.
// Pipeline: the ratio divider (31 stages, one quotient bit each), the
// limiter divider (FRAC_BITS + 2 stages) and nine stages of difference,
// select, multiply and rounding logic.
// When m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated. Bubbles travel as valid bits.
// Reset (aresetn low, synchronous) empties the pipeline and selects
// superbee.
`include "tvd_limited_slope_defines.svh"

module tvd_limited_slope
    import tvd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_centre_value,
    input  logic signed [DATA_W-1:0] s_next_value,
    input  logic signed [DATA_W-1:0] s_prev_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_limited_slope,
    output logic                     m_saturated
);

    localparam int DW1 = DATA_W;
    localparam int QB1 = R_QB;
    localparam int NW1 = DW1 + QB1;
    localparam int DW2 = (2 * FRAC_BITS + 2 > R_QB) ? 2 * FRAC_BITS + 2 : R_QB;
    localparam int QB2 = FRAC_BITS + 2;
    localparam int NW2 = DW2 + QB2;
    localparam int KW  = FRAC_BITS + 1;
    localparam int PW  = DATA_W + KW;
    localparam int SHW = DATA_W + FRAC_BITS;

    localparam logic [R_QB-1:0] ONE_R  = R_QB'(1) << FRAC_BITS;
    localparam logic [R_QB-1:0] HALF_R = R_QB'(1) << (FRAC_BITS - 1);
    localparam logic [R_QB-1:0] RM_MAX = '1;
    localparam logic [KW-1:0]   ONE_K  = KW'(1) << FRAC_BITS;
    localparam logic [PW-1:0]   HALF_P = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [DATA_W-1:0] nmag;
        logic              nneg;
        logic              rpos;
        logic              bz;
        logic              d0;
        logic              ovf;
        logic              sat;
        lim_mode_t         mode;
    } side1_t;

    typedef struct packed {
        logic [DATA_W-1:0] nmag;
        logic              nneg;
        logic              sat;
        logic              byp;
        logic [KW-1:0]     kdir;
    } side2_t;

    localparam int SW1 = $bits(side1_t);
    localparam int SW2 = $bits(side2_t);

    // Config
    lim_mode_t mode_reg;

    // Pipeline control
    logic pipe_en;

    // Stage A: clamped differences
    logic signed [DATA_W:0]   diff_n, diff_d;
    logic signed [DATA_W-1:0] num_next, den_next;
    logic                     sat_next;
    logic                     va_reg, sat_a_reg;
    logic signed [DATA_W-1:0] num_a_reg, den_a_reg;
    lim_mode_t                mode_a_reg;

    // Stage B: magnitudes and sign class
    logic              nneg_b_next, dneg_b_next, nz_b_next, dz_b_next;
    logic [DATA_W-1:0] nmag_b_next, dmag_abs;
    logic              vb_reg, nneg_b_reg, rpos_b_reg, bz_b_reg, d0_b_reg, sat_b_reg;
    logic [DATA_W-1:0] nmag_b_reg, dmag_b_reg;
    lim_mode_t         mode_b_reg;

    // Stage C: ratio overflow check and divider operands
    logic [SHW-1:0]    nsh;
    logic              ovf_c_next;
    logic              vc_reg;
    logic [NW1-1:0]    num1_c_reg;
    logic [DW1-1:0]    den1_c_reg;
    side1_t            side1_c_reg, side1_c_next;

    // Ratio divider output
    logic              v1;
    logic [QB1-1:0]    quo1;
    logic [SW1-1:0]    side1_o_raw;
    side1_t            side1_o;

    // Stage D: ratio
    logic [R_QB-1:0]   rm_d_next;
    logic              vd_reg, act_d_reg, big_d_reg;
    logic [R_QB-1:0]   rm_d_reg;
    side1_t            side1_d_reg;

    // Stage E: squares for van Albada
    logic [KW-1:0]     rl;
    logic [KW:0]       one_plus_rl;
    logic [2*KW:0]     qa_full;
    logic              ve_reg, act_e_reg, big_e_reg;
    logic [R_QB-1:0]   rm_e_reg;
    logic [2*KW-1:0]   sq_e_reg, qa_e_reg;
    side1_t            side1_e_reg;

    // Stage F: limiter select
    logic              byp_f;
    logic [KW-1:0]     kdir_f;
    logic [DW2-1:0]    q_f, d_f;
    logic              vf_reg;
    logic [NW2-1:0]    num2_f_reg;
    logic [DW2-1:0]    den2_f_reg;
    side2_t            side2_f_reg, side2_f_next;

    // Limiter divider output
    logic              v2;
    logic [QB2-1:0]    quo2;
    logic [SW2-1:0]    side2_o_raw;
    side2_t            side2_o;

    // Stage G: ksi
    logic [QB2:0]      rnd_g;
    logic [QB2-1:0]    kq_g;
    logic [KW-1:0]     ksi_g_next;
    logic              vg_reg, nneg_g_reg, sat_g_reg;
    logic [KW-1:0]     ksi_g_reg;
    logic [DATA_W-1:0] nmag_g_reg;

    // Stage H: product
    logic              vh_reg, nneg_h_reg, sat_h_reg;
    logic [PW-1:0]     prod_h_reg;
    logic [DATA_W-1:0] nmag_h_reg;

    // Output
    logic [PW-1:0]     rsum;
    logic [PW-FRAC_BITS-1:0] mag_full;
    logic [DATA_W-1:0] mag_o;
    logic              m_valid_reg, m_sat_reg;
    logic signed [DATA_W-1:0] m_slope_reg;

    // Limiter mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= LIM_SUPERBEE;
        end else if (cfg_wr_en) begin
            mode_reg <= lim_mode_t'(cfg_wr_data);
        end
    end

    // Whole pipeline moves unless a finished result is stuck
    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    // Stage A: differences with signed saturation
    always_comb begin
        diff_n   = {s_centre_value[DATA_W-1], s_centre_value}
                 - {s_prev_value[DATA_W-1], s_prev_value};
        diff_d   = {s_next_value[DATA_W-1], s_next_value}
                 - {s_centre_value[DATA_W-1], s_centre_value};
        num_next = (diff_n[DATA_W] != diff_n[DATA_W-1])
                 ? (diff_n[DATA_W] ? S_MIN : S_MAX) : diff_n[DATA_W-1:0];
        den_next = (diff_d[DATA_W] != diff_d[DATA_W-1])
                 ? (diff_d[DATA_W] ? S_MIN : S_MAX) : diff_d[DATA_W-1:0];
        sat_next = (diff_n[DATA_W] != diff_n[DATA_W-1])
                || (diff_d[DATA_W] != diff_d[DATA_W-1]);
    end

    // Stage B: magnitudes, zero tests, ratio sign
    always_comb begin
        nneg_b_next = num_a_reg[DATA_W-1];
        dneg_b_next = den_a_reg[DATA_W-1];
        nz_b_next   = num_a_reg != '0;
        dz_b_next   = den_a_reg != '0;
        nmag_b_next = nneg_b_next ? ($unsigned(DATA_W'(0)) - $unsigned(num_a_reg))
                                  : $unsigned(num_a_reg);
        dmag_abs    = dneg_b_next ? ($unsigned(DATA_W'(0)) - $unsigned(den_a_reg))
                                  : $unsigned(den_a_reg);
    end

    // Stage C: ratio saturates when (nmag << F) >> 31 reaches dmag
    always_comb begin
        nsh          = {nmag_b_reg, {FRAC_BITS{1'b0}}};
        ovf_c_next   = DATA_W'(nsh[SHW-1:R_QB]) >= dmag_b_reg;
        side1_c_next = '{nmag: nmag_b_reg, nneg: nneg_b_reg, rpos: rpos_b_reg,
                         bz: bz_b_reg, d0: d0_b_reg, ovf: ovf_c_next,
                         sat: sat_b_reg, mode: mode_b_reg};
    end

    assign side1_o = side1_t'(side1_o_raw);

    // Stage D: ratio with special cases
    always_comb begin
        if (side1_o.bz) begin
            rm_d_next = ONE_R;
        end else if (side1_o.d0 || side1_o.ovf) begin
            rm_d_next = RM_MAX;
        end else begin
            rm_d_next = quo1;
        end
    end

    // Stage E: r^2 and r(1+r), only meaningful for r <= 1
    always_comb begin
        rl          = rm_d_reg[KW-1:0];
        one_plus_rl = (KW+1)'(ONE_K) + (KW+1)'(rl);
        qa_full     = (2*KW+1)'(rl) * (2*KW+1)'(one_plus_rl);
    end

    // Stage F: pick the limiter, or set up a division
    always_comb begin
        byp_f  = 1'b1;
        kdir_f = '0;
        q_f    = '0;
        d_f    = DW2'(1);
        if (act_e_reg) begin
            if (big_e_reg) begin
                // cap 1/r
                byp_f = 1'b0;
                q_f   = DW2'(ONE_R);
                d_f   = DW2'(rm_e_reg);
            end else begin
                case (side1_e_reg.mode)
                    LIM_SUPERBEE: begin
                        kdir_f = (rm_e_reg <= HALF_R) ? (rm_e_reg[KW-1:0] << 1) : ONE_K;
                    end
                    LIM_MINBEE: begin
                        kdir_f = rm_e_reg[KW-1:0];
                    end
                    LIM_VANLEER: begin
                        byp_f = 1'b0;
                        q_f   = DW2'(rm_e_reg[KW-1:0]) << 1;
                        d_f   = DW2'(ONE_R) + DW2'(rm_e_reg[KW-1:0]);
                    end
                    LIM_VANALBADA: begin
                        byp_f = 1'b0;
                        q_f   = DW2'(qa_e_reg);
                        d_f   = DW2'(sq_e_reg) + (DW2'(1) << (2 * FRAC_BITS));
                    end
                    default: begin
                        kdir_f = '0;
                    end
                endcase
            end
        end
        side2_f_next = '{nmag: side1_e_reg.nmag, nneg: side1_e_reg.nneg,
                         sat: side1_e_reg.sat, byp: byp_f, kdir: kdir_f};
    end

    assign side2_o = side2_t'(side2_o_raw);

    // Stage G: round the quotient, clamp to one
    always_comb begin
        rnd_g = (QB2+1)'(quo2) + (QB2+1)'(1);
        kq_g  = rnd_g[QB2:1];
        if (side2_o.byp) begin
            ksi_g_next = side2_o.kdir;
        end else if (kq_g > QB2'(ONE_K)) begin
            ksi_g_next = ONE_K;
        end else begin
            ksi_g_next = kq_g[KW-1:0];
        end
    end

    // Output stage: round, clamp to |num|, restore sign
    always_comb begin
        rsum     = prod_h_reg + HALF_P;
        mag_full = rsum[PW-1:FRAC_BITS];
        mag_o    = (mag_full > (PW-FRAC_BITS)'(nmag_h_reg)) ? nmag_h_reg
                                                          : mag_full[DATA_W-1:0];
    end

    // Valid bits for the local stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            vc_reg      <= 1'b0;
            vd_reg      <= 1'b0;
            ve_reg      <= 1'b0;
            vf_reg      <= 1'b0;
            vg_reg      <= 1'b0;
            vh_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            va_reg      <= s_valid;
            vb_reg      <= va_reg;
            vc_reg      <= vb_reg;
            vd_reg      <= v1;
            ve_reg      <= vd_reg;
            vf_reg      <= ve_reg;
            vg_reg      <= v2;
            vh_reg      <= vg_reg;
            m_valid_reg <= vh_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            num_a_reg   <= num_next;
            den_a_reg   <= den_next;
            sat_a_reg   <= sat_next;
            mode_a_reg  <= mode_reg;

            nmag_b_reg  <= nmag_b_next;
            dmag_b_reg  <= dz_b_next ? dmag_abs : DATA_W'(1);
            nneg_b_reg  <= nneg_b_next;
            bz_b_reg    <= !nz_b_next && !dz_b_next;
            d0_b_reg    <= nz_b_next && !dz_b_next;
            rpos_b_reg  <= (!nz_b_next && !dz_b_next) ? 1'b1
                         : (!dz_b_next ? !nneg_b_next
                                       : ((nneg_b_next == dneg_b_next) && nz_b_next));
            sat_b_reg   <= sat_a_reg;
            mode_b_reg  <= mode_a_reg;

            num1_c_reg  <= ovf_c_next ? '0 : NW1'(nsh);
            den1_c_reg  <= dmag_b_reg;
            side1_c_reg <= side1_c_next;

            rm_d_reg    <= rm_d_next;
            act_d_reg   <= side1_o.rpos && (rm_d_next != '0);
            big_d_reg   <= rm_d_next > ONE_R;
            side1_d_reg <= side1_o;

            rm_e_reg    <= rm_d_reg;
            act_e_reg   <= act_d_reg;
            big_e_reg   <= big_d_reg;
            sq_e_reg    <= (2*KW)'(rl) * (2*KW)'(rl);
            qa_e_reg    <= qa_full[2*KW-1:0];
            side1_e_reg <= side1_d_reg;

            num2_f_reg  <= NW2'(q_f) << (FRAC_BITS + 1);
            den2_f_reg  <= d_f;
            side2_f_reg <= side2_f_next;

            ksi_g_reg   <= ksi_g_next;
            nmag_g_reg  <= side2_o.nmag;
            nneg_g_reg  <= side2_o.nneg;
            sat_g_reg   <= side2_o.sat;

            prod_h_reg  <= PW'(nmag_g_reg) * PW'(ksi_g_reg);
            nmag_h_reg  <= nmag_g_reg;
            nneg_h_reg  <= nneg_g_reg;
            sat_h_reg   <= sat_g_reg;

            m_slope_reg <= nneg_h_reg ? $signed(DATA_W'(0) - mag_o) : $signed(mag_o);
            m_sat_reg   <= sat_h_reg;
        end
    end

    // Ratio r = (|num| << F) / |den|
    tvd_div_pipe #(
        .QB (QB1),
        .DW (DW1),
        .SW (SW1)
    ) u_ratio_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (vc_reg),
        .in_num    (num1_c_reg),
        .in_den    (den1_c_reg),
        .in_side   (SW1'(side1_c_reg)),
        .out_valid (v1),
        .out_quo   (quo1),
        .out_side  (side1_o_raw)
    );

    // Limiter quotient, F+1 fraction bits before rounding
    tvd_div_pipe #(
        .QB (QB2),
        .DW (DW2),
        .SW (SW2)
    ) u_ksi_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (vf_reg),
        .in_num    (num2_f_reg),
        .in_den    (den2_f_reg),
        .in_side   (SW2'(side2_f_reg)),
        .out_valid (v2),
        .out_quo   (quo2),
        .out_side  (side2_o_raw)
    );

    assign m_valid         = m_valid_reg;
    assign m_limited_slope = m_slope_reg;
    assign m_saturated     = m_sat_reg;

    `TVD_ASSERT_IMP(a_ksi_range, vg_reg, ksi_g_reg <= ONE_K)
    `TVD_ASSERT_IMP(a_sat_extreme, va_reg && sat_a_reg, (num_a_reg == S_MIN) || (num_a_reg == S_MAX) || (den_a_reg == S_MIN) || (den_a_reg == S_MAX))
    `TVD_ASSERT_NXT(a_stall_hold, m_valid_reg && !m_ready, $stable(vh_reg) && $stable(vg_reg))

endmodule

// ----- sv/tvd_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Requires num < den << QB; quotient is floor(num / den).
module tvd_div_pipe #(
    parameter int QB = 31,
    parameter int DW = 32,
    parameter int SW = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DW+QB-1:0]   in_num,
    input  logic [DW-1:0]      in_den,
    input  logic [SW-1:0]      in_side,
    output logic               out_valid,
    output logic [QB-1:0]      out_quo,
    output logic [SW-1:0]      out_side
);

    localparam int NW = DW + QB;

    logic          valid_reg [QB];
    logic [NW-1:0] rem_reg   [QB];
    logic [DW-1:0] den_reg   [QB];
    logic [QB-1:0] quo_reg   [QB];
    logic [SW-1:0] side_reg  [QB];

    logic          src_valid [QB];
    logic [NW-1:0] src_rem   [QB];
    logic [DW-1:0] src_den   [QB];
    logic [QB-1:0] src_quo   [QB];
    logic [SW-1:0] src_side  [QB];
    logic [NW-1:0] trial     [QB];
    logic          ge        [QB];
    logic [NW-1:0] rem_next  [QB];
    logic [QB-1:0] quo_next  [QB];

    // Stage inputs: first stage from the port, others from the stage before
    always_comb begin
        src_valid[0] = in_valid;
        src_rem[0]   = in_num;
        src_den[0]   = in_den;
        src_quo[0]   = '0;
        src_side[0]  = in_side;
        for (int k = 1; k < QB; k++) begin
            src_valid[k] = valid_reg[k-1];
            src_rem[k]   = rem_reg[k-1];
            src_den[k]   = den_reg[k-1];
            src_quo[k]   = quo_reg[k-1];
            src_side[k]  = side_reg[k-1];
        end
    end

    // One compare-subtract per stage, MSB first
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            trial[k]    = NW'(src_den[k]) << (QB - 1 - k);
            ge[k]       = src_rem[k] >= trial[k];
            rem_next[k] = ge[k] ? (src_rem[k] - trial[k]) : src_rem[k];
            quo_next[k] = src_quo[k] | (ge[k] ? (QB'(1) << (QB - 1 - k)) : '0);
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QB; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < QB; k++) valid_reg[k] <= src_valid[k];
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QB; k++) begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= src_den[k];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign out_valid = valid_reg[QB-1];
    assign out_quo   = quo_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

// ----- tb/sv/tvd_limited_slope_test.sv -----
`timescale 1ns / 1ps

module tvd_limited_slope_test;
    import tvd_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int PIPE_CYCLES = 42 + FB;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM = 500;

    typedef struct packed {
        logic signed [DATA_W-1:0] centre;
        logic signed [DATA_W-1:0] next;
        logic signed [DATA_W-1:0] prev;
    } cell_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] slope;
        logic                     sat;
    } slope_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [1:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    logic signed [DATA_W-1:0] s_centre_value;
    logic signed [DATA_W-1:0] s_next_value;
    logic signed [DATA_W-1:0] s_prev_value;
    logic m_valid;
    logic m_ready;
    logic signed [DATA_W-1:0] m_limited_slope;
    logic m_saturated;

    tvd_limited_slope #(.FRAC_BITS(FB)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_centre_value(s_centre_value),
        .s_next_value(s_next_value),
        .s_prev_value(s_prev_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_limited_slope(m_limited_slope),
        .m_saturated(m_saturated)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    cell_req_t pending_cells[$];
    slope_t    expected_slopes[$];
    lim_mode_t limiter;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;
    int        mismatches;
    int        quiet_cycles;

    // rounded q * 2^FB / d, ties up
    function automatic longint unsigned round_ratio(longint unsigned q,
                                                    longint unsigned d);
        longint unsigned quo;
        longint unsigned rem;
        quo = q / d;
        rem = q % d;
        for (int i = 0; i < FB + 1; i++) begin
            quo = quo << 1;
            rem = rem << 1;
            if (rem >= d) begin
                rem = rem - d;
                quo = quo | 1;
            end
        end
        return (quo + 1) >> 1;
    endfunction

    function automatic slope_t limited_slope_of(cell_req_t c, lim_mode_t mode);
        longint unsigned one;
        longint signed   num;
        longint signed   den;
        longint unsigned nmag;
        longint unsigned dmag;
        longint unsigned rmag;
        longint unsigned ksi;
        longint unsigned mag;
        logic            rpos;
        slope_t          res;
        one = longint'(1) << FB;
        res.sat = 1'b0;
        num = longint'(c.centre) - longint'(c.prev);
        den = longint'(c.next) - longint'(c.centre);
        // differences clamp to 32 bits
        if (num > 64'sh7FFFFFFF) begin num = 64'sh7FFFFFFF; res.sat = 1'b1; end
        if (num < -64'sh80000000) begin num = -64'sh80000000; res.sat = 1'b1; end
        if (den > 64'sh7FFFFFFF) begin den = 64'sh7FFFFFFF; res.sat = 1'b1; end
        if (den < -64'sh80000000) begin den = -64'sh80000000; res.sat = 1'b1; end
        nmag = num < 0 ? -num : num;
        dmag = den < 0 ? -den : den;
        ksi = 0;
        if (num == 0 && den == 0) begin
            rpos = 1'b1;
            rmag = one;
        end else if (den == 0) begin
            rpos = num > 0;
            rmag = 64'h7FFFFFFF;
        end else begin
            rpos = ((num > 0) == (den > 0)) && num != 0;
            rmag = (nmag << FB) / dmag;
            if (rmag > 64'h7FFFFFFF) rmag = 64'h7FFFFFFF;
        end
        if (rpos && rmag != 0) begin
            if (rmag > one) begin
                ksi = round_ratio(one, rmag);
            end else begin
                case (mode)
                    LIM_SUPERBEE: ksi = (rmag <= one / 2) ? 2 * rmag : one;
                    LIM_MINBEE: ksi = rmag;
                    LIM_VANLEER: ksi = round_ratio(2 * rmag, one + rmag);
                    default: ksi = round_ratio(rmag * (one + rmag),
                                               one * one + rmag * rmag);
                endcase
            end
            if (ksi > one) ksi = one;
        end
        mag = (nmag * ksi + (one >> 1)) >> FB;
        if (mag > nmag) mag = nmag;
        res.slope = DATA_W'(num < 0 ? -longint'(mag) : longint'(mag));
        return res;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 8) << FB;
            3: return $urandom_range(0, 1) ? $urandom_range(0, 300) : -$urandom_range(0, 300);
            default: return $urandom;
        endcase
    endfunction

    // mostly a smooth-ish neighborhood (both differences small and related), else random values
    function automatic cell_req_t random_cell();
        cell_req_t c;
        int dn;
        int dd;
        if ($urandom_range(0, 3) == 0) begin
            c.centre = random_value();
            c.next = random_value();
            c.prev = random_value();
        end else begin
            c.centre = $urandom;
            c.centre = c.centre >>> $urandom_range(0, 8);
            dn = $signed($urandom) >>> $urandom_range(4, 24);
            dd = $urandom_range(0, 7) == 0 ? dn * 0 : $signed($urandom) >>> $urandom_range(4, 24);
            if ($urandom_range(0, 2) == 0) dd = dn + ($signed($urandom) >>> 26);
            c.prev = c.centre - dn;
            c.next = c.centre + dd;
        end
        return c;
    endfunction

    function automatic cell_req_t make_cell(int c, int n, int p);
        cell_req_t r;
        r.centre = c;
        r.next = n;
        r.prev = p;
        return r;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_cells.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cell_req_t c;
                c = pending_cells.pop_front();
                s_valid <= 1'b1;
                s_centre_value <= c.centre;
                s_next_value <= c.next;
                s_prev_value <= c.prev;
                expected_slopes.push_back(limited_slope_of(c, limiter));
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result ready, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // result monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_slopes.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h sat %b", m_limited_slope, m_saturated);
                end else begin
                    slope_t e;
                    e = expected_slopes.pop_front();
                    if (e.slope !== m_limited_slope || e.sat !== m_saturated) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected slope %h sat %b, got %h sat %b",
                                     e.slope, e.sat, m_limited_slope, m_saturated);
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tvd_limited_slope_test: errors");
                $finish;
            end
        end
    end

    task automatic drain_and_set(lim_mode_t mode);
        while (pending_cells.size() > 0 || s_valid || expected_slopes.size() > 0)
            @(posedge aclk);
        repeat (PIPE_CYCLES + 4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        limiter <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_directed();
        pending_cells.push_back(make_cell(0, 0, 0));
        pending_cells.push_back(make_cell(5 << FB, 5 << FB, 3 << FB));
        pending_cells.push_back(make_cell(5 << FB, 5 << FB, 7 << FB));
        pending_cells.push_back(make_cell(1 << FB, 2 << FB, 0));
        pending_cells.push_back(make_cell(1 << FB, 5 << FB, 0));
        pending_cells.push_back(make_cell(3 << FB, 4 << FB, 0));
        pending_cells.push_back(make_cell(1 << FB, 3 << FB, 0));
        pending_cells.push_back(make_cell(1 << FB, 0, 0));
        pending_cells.push_back(make_cell(1, 32'h7FFFFFFF, 0));
        pending_cells.push_back(make_cell(32'h7FFFFFFF, 32'h80000000, 32'h80000000));
        pending_cells.push_back(make_cell(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_cells.push_back(make_cell(-100, -300, 100));
        pending_cells.push_back(make_cell(7, 9, 3));
        pending_cells.push_back(make_cell(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        pending_cells.push_back(make_cell(0, 32'h7FFFFFFF, 32'h80000000));
        pending_cells.push_back(make_cell(0, 32'h80000000, 32'h7FFFFFFF));
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) pending_cells.push_back(random_cell());
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = LIM_SUPERBEE;
        s_valid = 1'b0;
        s_centre_value = '0;
        s_next_value = '0;
        s_prev_value = '0;
        m_ready = 1'b0;
        limiter = LIM_SUPERBEE;
        send_idle_pct = 17;
        recv_idle_pct = 61;
        hold_off_cycles = 0;
        mismatches = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset mode, then every limiter on the directed set
        queue_directed();
        for (int m = 0; m < 4; m++) begin
            drain_and_set(lim_mode_t'(m));
            queue_directed();
        end

        // random phases across limiters and idle profiles
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_set(lim_mode_t'($urandom_range(0, 3)));
            if (ph == 2) begin
                send_idle_pct = 61;
                recv_idle_pct = 17;
            end
            if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_off_cycles <= 3 * PIPE_CYCLES;
            end
            queue_random(N_RANDOM / 6);
        end
        drain_and_set(LIM_VANALBADA);
        queue_random(20);

        while (pending_cells.size() > 0 || s_valid || expected_slopes.size() > 0)
            @(posedge aclk);
        repeat (PIPE_CYCLES + 4) @(posedge aclk);
        if (mismatches == 0)
            $display("tvd_limited_slope_test: clean");
        else
            $display("tvd_limited_slope_test: errors");
        $finish;
    end
endmodule
